>>> design/ibs_pkg.sv
package ibs_pkg;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_FALLBACK,
    OP_BILINEAR,
    OP_CUBIC,
    OP_BLACK
  } ibs_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_CALC,
    ST_DONE
  } ibs_state_e;

  localparam logic       CMD_WRITE     = 1'b0;
  localparam logic [1:0] MODE_BILINEAR = 2'd0;
  localparam logic [1:0] MODE_CUBIC    = 2'd1;

  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 9;
  localparam int SIZE_W     = 9;
  localparam int MODE_W     = 2;
  localparam int SIZE_RESET = 256;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 24;
  localparam int POS_W      = 16;
  localparam int OUT_W      = 19;
  localparam int OUT_MAX    = 262143;
  localparam int OUT_MIN    = -262144;

endpackage

>>> design/ibs_ifs.sv
interface ibs_in_if import ibs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               command;
  logic [CH_W-1:0]    pixel_row;
  logic [CH_W-1:0]    pixel_col;
  logic [CH_W-1:0]    red_in;
  logic [CH_W-1:0]    green_in;
  logic [CH_W-1:0]    blue_in;
  logic [POS_W-1:0]   sample_row;
  logic [POS_W-1:0]   sample_col;

  modport source (output valid, command, pixel_row, pixel_col, red_in, green_in, blue_in,
                  sample_row, sample_col, input ready);
  modport sink (input valid, command, pixel_row, pixel_col, red_in, green_in, blue_in,
                sample_row, sample_col, output ready);
endinterface

interface ibs_out_if import ibs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] red_out;
  logic signed [OUT_W-1:0] green_out;
  logic signed [OUT_W-1:0] blue_out;
  logic                    edge_fallback;

  modport source (output valid, red_out, green_out, blue_out, edge_fallback, input ready);
  modport sink (input valid, red_out, green_out, blue_out, edge_fallback, output ready);
endinterface

>>> design/ibs_front.sv
module ibs_front import ibs_pkg::*; #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256,
  parameter int FRAC_BITS  = 8,
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int CLW = $clog2(MAX_WIDTH),
  localparam int EW  = $bits(ibs_op_e) + RW + CLW + 2 * FRAC_BITS + PIX_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  ibs_in_if.sink            in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [EW-1:0]     push_data_o
);

  localparam int CMPW = 16;
  localparam logic signed [POS_W:0] HALF_PIX = (POS_W+1)'(2 ** (FRAC_BITS - 1));

  typedef struct packed {
    ibs_op_e              op;
    logic [RW-1:0]        row;
    logic [CLW-1:0]       col;
    logic [FRAC_BITS-1:0] frac_r;
    logic [FRAC_BITS-1:0] frac_c;
    logic [PIX_W-1:0]     rgb;
  } entry_t;

  logic [SIZE_W-1:0] height_q, width_q;
  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= SIZE_W'(SIZE_RESET);
      width_q  <= SIZE_W'(SIZE_RESET);
      mode_q   <= MODE_BILINEAR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [POS_W:0] vr, vc, flr, flc;
  logic [CMPW-1:0] rb, cb, heff, weff, hraw, wraw, fr, fc;
  logic fall_bl, fall_cu, fall, row_ok, col_ok;
  entry_t ent;

  always_comb begin
    vr   = $signed({1'b0, in_i.sample_row}) - HALF_PIX;
    vc   = $signed({1'b0, in_i.sample_col}) - HALF_PIX;
    flr  = vr >>> FRAC_BITS;
    flc  = vc >>> FRAC_BITS;
    rb   = flr[POS_W] ? '0 : flr[CMPW-1:0];
    cb   = flc[POS_W] ? '0 : flc[CMPW-1:0];
    hraw = CMPW'(height_q);
    wraw = CMPW'(width_q);
    if (hraw == '0) heff = CMPW'(1);
    else if (hraw > CMPW'(MAX_HEIGHT)) heff = CMPW'(MAX_HEIGHT);
    else heff = hraw;
    if (wraw == '0) weff = CMPW'(1);
    else if (wraw > CMPW'(MAX_WIDTH)) weff = CMPW'(MAX_WIDTH);
    else weff = wraw;
    fall_bl = (rb + CMPW'(1) >= heff) || (cb + CMPW'(1) >= weff);
    fall_cu = (rb + CMPW'(3) >= heff) || (rb == '0) || (cb + CMPW'(2) >= weff) || (cb == '0);
    fall    = (mode_q == MODE_BILINEAR) ? fall_bl : fall_cu;
    fr      = (rb < heff) ? rb : heff - CMPW'(1);
    fc      = (cb < weff) ? cb : weff - CMPW'(1);
    row_ok  = CMPW'(in_i.pixel_row) < CMPW'(MAX_HEIGHT);
    col_ok  = CMPW'(in_i.pixel_col) < CMPW'(MAX_WIDTH);

    ent.frac_r = vr[FRAC_BITS-1:0];
    ent.frac_c = vc[FRAC_BITS-1:0];
    ent.rgb    = '0;
    ent.row    = RW'(rb);
    ent.col    = CLW'(cb);
    if (in_i.command == CMD_WRITE) begin
      ent.op  = OP_WRITE;
      ent.row = RW'(in_i.pixel_row);
      ent.col = CLW'(in_i.pixel_col);
      ent.rgb = {in_i.red_in, in_i.green_in, in_i.blue_in};
    end else if (mode_q != MODE_BILINEAR && mode_q != MODE_CUBIC) begin
      ent.op = OP_BLACK;
    end else if (fall) begin
      ent.op  = OP_FALLBACK;
      ent.row = RW'(fr);
      ent.col = CLW'(fc);
    end else if (mode_q == MODE_BILINEAR) begin
      ent.op = OP_BILINEAR;
    end else begin
      ent.op  = OP_CUBIC;
      ent.row = RW'(rb - CMPW'(1));
      ent.col = CLW'(cb - CMPW'(1));
    end
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && ((in_i.command != CMD_WRITE) || (row_ok && col_ok));
  assign push_data_o  = ent;

endmodule

>>> design/ibs_queue.sv
module ibs_queue #(
  parameter int W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int DEPTH = 2;

  logic [W-1:0] slot_q [DEPTH];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = cnt_q != 2'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slot_q[rp_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wp_q] <= push_data_i;
  end

endmodule

>>> design/ibs_back.sv
module ibs_back import ibs_pkg::*; #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256,
  parameter int FRAC_BITS  = 8,
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int CLW = $clog2(MAX_WIDTH),
  localparam int EW  = $bits(ibs_op_e) + RW + CLW + 2 * FRAC_BITS + PIX_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [EW-1:0] pop_data_i,
  ibs_out_if.source     res_o
);

  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = FRAC_BITS + 17;
  localparam int PW    = VW + FRAC_BITS + 1;
  localparam int SW    = PW + 1;
  localparam logic signed [PW-1:0] HALF1 = PW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] HALF2 = SW'(1) <<< (2 * FRAC_BITS - 1);

  typedef struct packed {
    ibs_op_e              op;
    logic [RW-1:0]        row;
    logic [CLW-1:0]       col;
    logic [FRAC_BITS-1:0] frac_r;
    logic [FRAC_BITS-1:0] frac_c;
    logic [PIX_W-1:0]     rgb;
  } entry_t;

  entry_t head;
  assign head = entry_t'(pop_data_i);

  ibs_state_e state_q, state_d;
  ibs_op_e op_q;
  logic [RW-1:0] base_r_q;
  logic [CLW-1:0] base_c_q;
  logic [FRAC_BITS-1:0] fr_q, fc_q, t_cur;
  logic [1:0] lim_q, rcnt_q, ccnt_q, rd_r_q, rd_c_q;
  logic [2:0] step_q, pass_q;
  logic rd_vld_q, out_valid_q;
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic [PIX_W-1:0] win_q [4][4];
  logic [AW-1:0] head_addr, cur_addr, mem_addr;
  logic pop, mem_we, rd_issue, calc_en, load_out, rd_last, calc_last, win_shift;
  logic [OUT_W-1:0] lane_out [3];
  logic [OUT_W-1:0] red_q, green_q, blue_q;
  logic edge_q;

  assign rd_last   = (rcnt_q == lim_q) && (ccnt_q == lim_q);
  assign calc_last = (op_q == OP_BILINEAR) ? (step_q == 3'd4)
                                           : (step_q == 3'd6 && pass_q == 3'd4);
  assign win_shift = calc_en && op_q == OP_CUBIC && step_q == 3'd6 && pass_q != 3'd4;
  assign t_cur     = (op_q == OP_CUBIC) ? ((pass_q == 3'd4) ? fr_q : fc_q)
                                        : ((step_q >= 3'd2) ? fr_q : fc_q);

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    rd_issue = 1'b0;
    calc_en  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop    = pop_valid_i;
        mem_we = pop_valid_i && head.op == OP_WRITE;
      end
      ST_READ: rd_issue = 1'b1;
      ST_CALC: calc_en = 1'b1;
      ST_DONE: load_out = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          case (head.op)
            OP_WRITE: state_d = ST_IDLE;
            OP_BLACK: state_d = ST_DONE;
            default:  state_d = ST_READ;
          endcase
        end
      end
      ST_READ:  if (rd_last) state_d = ST_DRAIN;
      ST_DRAIN: state_d = (op_q == OP_FALLBACK) ? ST_DONE : ST_CALC;
      ST_CALC:  if (calc_last) state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign pop_ready_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rcnt_q      <= '0;
      ccnt_q      <= '0;
      lim_q       <= '0;
      step_q      <= '0;
      pass_q      <= '0;
      op_q        <= OP_WRITE;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_issue;
      if (load_out) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      if (pop) begin
        op_q   <= head.op;
        rcnt_q <= '0;
        ccnt_q <= '0;
        step_q <= '0;
        pass_q <= '0;
        case (head.op)
          OP_BILINEAR: lim_q <= 2'd1;
          OP_CUBIC:    lim_q <= 2'd3;
          default:     lim_q <= 2'd0;
        endcase
      end else if (rd_issue) begin
        if (ccnt_q == lim_q) begin
          ccnt_q <= '0;
          rcnt_q <= rcnt_q + 2'd1;
        end else begin
          ccnt_q <= ccnt_q + 2'd1;
        end
      end else if (calc_en) begin
        if (op_q == OP_CUBIC && step_q == 3'd6) begin
          step_q <= '0;
          pass_q <= pass_q + 3'd1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      base_r_q <= head.row;
      base_c_q <= head.col;
      fr_q     <= head.frac_r;
      fc_q     <= head.frac_c;
    end
  end

  // single-port pixel memory
  assign head_addr = AW'(head.row) * AW'(MAX_WIDTH) + AW'(head.col);
  assign cur_addr  = AW'(base_r_q + RW'(rcnt_q)) * AW'(MAX_WIDTH)
                   + AW'(base_c_q + CLW'(ccnt_q));
  assign mem_addr  = mem_we ? head_addr : cur_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= head.rgb;
    else rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    rd_r_q <= rcnt_q;
    rd_c_q <= ccnt_q;
    if (rd_vld_q) begin
      win_q[rd_r_q][rd_c_q] <= rdata_q;
    end else if (win_shift) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          win_q[r][c] <= win_q[r+1][c];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic signed [VW-1:0] px [4][4];
    logic signed [VW-1:0] sc [4][4];
    logic signed [VW-1:0] q [4];
    logic signed [VW-1:0] a_q, b_q, c_q, p1_q, acc_q, res_q, ma, rs_val, fin;
    logic signed [VW-1:0] rows_q [4];
    logic signed [PW-1:0] prod_q, prod_d, rnd, rsv;
    logic signed [SW-1:0] bsum, bres;
    logic signed [FRAC_BITS:0] tsig;

    for (genvar r = 0; r < 4; r++) begin : g_r
      for (genvar c = 0; c < 4; c++) begin : g_c
        assign px[r][c] = $signed(VW'(win_q[r][c][PIX_W-1-CH_W*ch -: CH_W]));
        assign sc[r][c] = px[r][c] <<< FRAC_BITS;
      end
      assign q[r] = (pass_q == 3'd4) ? rows_q[r] : sc[0][r];
    end

    always_comb begin
      case (step_q)
        3'd0:    ma = px[0][1] - px[0][0];
        3'd1:    ma = (op_q == OP_CUBIC) ? a_q + b_q : px[1][1] - px[1][0];
        3'd3:    ma = (op_q == OP_CUBIC) ? acc_q : c_q - acc_q;
        default: ma = acc_q;
      endcase
      tsig   = $signed({1'b0, t_cur});
      prod_d = ma * tsig;
      rnd    = prod_q + HALF1;
      rsv    = rnd >>> FRAC_BITS;
      rs_val = rsv[VW-1:0];
      bsum   = (SW'(acc_q) <<< FRAC_BITS) + SW'(prod_q) + HALF2;
      bres   = bsum >>> (2 * FRAC_BITS);
    end

    always_ff @(posedge clk_i) begin
      if (calc_en) begin
        if (op_q == OP_CUBIC) begin
          case (step_q)
            3'd0: begin
              a_q  <= q[3] - q[2];
              b_q  <= q[1] - q[0];
              c_q  <= q[2] - q[0];
              p1_q <= q[1];
            end
            3'd2:    acc_q <= rs_val - a_q - (b_q <<< 1);
            3'd4:    acc_q <= rs_val + c_q;
            3'd6: begin
              if (pass_q == 3'd4) res_q <= p1_q + rs_val;
              else rows_q[pass_q[1:0]] <= p1_q + rs_val;
            end
            default: prod_q <= prod_d;
          endcase
        end else begin
          case (step_q)
            3'd0: prod_q <= prod_d;
            3'd1: begin
              acc_q  <= sc[0][0] + prod_q[VW-1:0];
              prod_q <= prod_d;
            end
            3'd2:    c_q <= sc[1][0] + prod_q[VW-1:0];
            3'd3:    prod_q <= prod_d;
            default: res_q <= bres[VW-1:0];
          endcase
        end
      end
    end

    always_comb begin
      case (op_q)
        OP_BLACK:    fin = '0;
        OP_FALLBACK: fin = sc[0][0];
        default:     fin = res_q;
      endcase
      if (fin > VW'(OUT_MAX)) lane_out[ch] = OUT_W'(OUT_MAX);
      else if (fin < VW'(OUT_MIN)) lane_out[ch] = OUT_W'(OUT_MIN);
      else lane_out[ch] = fin[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      red_q   <= lane_out[0];
      green_q <= lane_out[1];
      blue_q  <= lane_out[2];
      edge_q  <= op_q == OP_FALLBACK;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.red_out       = red_q;
  assign res_o.green_out     = green_q;
  assign res_o.blue_out      = blue_q;
  assign res_o.edge_fallback = edge_q;

`ifndef ASSERT_OFF
  a_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_READ)
    else $error("read data without a read cycle");
  a_calc_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> (op_q == OP_BILINEAR || op_q == OP_CUBIC))
    else $error("calc phase for an op without interpolation");
  a_start_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d != ST_IDLE) |-> pop)
    else $error("left idle without taking a queue entry");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("result load lost");
`endif

endmodule

>>> design/image_bilinear_bicubic_sampler.sv
// Pixel store with bilinear and cubic sampling. Write transactions store one RGB pixel and
// give no result; sample transactions give one result each, in order. The front decodes each
// transaction and the edge rule in the cycle it is taken and places it in a two-entry queue;
// the back works through the queue one entry at a time. A write is stored as it is popped,
// an unknown-mode sample gives black, an edge fallback reads one pixel, a bilinear sample
// reads four and a cubic sample reads 16 from the single-port pixel memory, then runs 5
// four-tap passes on the one multiplier of each color lane. The pixel memory has no reset
// and must be written before it is sampled.
module image_bilinear_bicubic_sampler import ibs_pkg::*; #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  ibs_in_if.sink            in_i,
  ibs_out_if.source         result_o
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int EW  = $bits(ibs_op_e) + RW + CLW + 2 * FRAC_BITS + PIX_W;

  logic push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  ibs_front #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  ibs_queue #(
    .W(EW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  ibs_back #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .res_o      (result_o)
  );

endmodule

>>> bench/ibs_sample_checker.sv
`timescale 1ns / 100ps

module ibs_sample_checker import ibs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  ibs_in_if                 in_i,
  ibs_out_if                result_o,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       samples_o
);

  localparam int FRAC = 8;
  localparam int STORE_DIM = 256;

  typedef struct packed {
    logic signed [OUT_W-1:0] red;
    logic signed [OUT_W-1:0] green;
    logic signed [OUT_W-1:0] blue;
    logic                    fallback;
  } color_t;

  logic [PIX_W-1:0]  pixel_mem [0:STORE_DIM*STORE_DIM-1];
  logic [SIZE_W-1:0] height_q;
  logic [SIZE_W-1:0] width_q;
  logic [MODE_W-1:0] mode_q;
  color_t            color_fifo [$];

  assign pending_o = color_fifo.size();

  function automatic longint texel(int r, int c, int ch);
    logic [PIX_W-1:0] p;
    if (r < 0 || c < 0 || r >= STORE_DIM || c >= STORE_DIM) return 0;
    p = pixel_mem[r*STORE_DIM + c];
    return longint'((p >> (16 - 8*ch)) & 24'hff);
  endfunction

  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FRAC-1))) >>> FRAC;
  endfunction

  function automatic longint cubic4(longint p0, longint p1, longint p2, longint p3,
                                    longint t);
    longint a, b, c, t1, t2;
    a  = p3 - p2;
    b  = p1 - p0;
    c  = p2 - p0;
    t1 = round_frac((a + b) * t) - a - 2*b;
    t2 = round_frac(t1 * t) + c;
    return p1 + round_frac(t2 * t);
  endfunction

  function automatic logic signed [OUT_W-1:0] clip(longint v);
    if (v < OUT_MIN) v = OUT_MIN;
    if (v > OUT_MAX) v = OUT_MAX;
    return v[OUT_W-1:0];
  endfunction

  function automatic int eff_size(logic [SIZE_W-1:0] r);
    if (r == 0) return 1;
    if (r > STORE_DIM) return STORE_DIM;
    return int'(r);
  endfunction

  function automatic color_t sample_color(logic [POS_W-1:0] rpos, logic [POS_W-1:0] cpos);
    int     h, w, rb, cb, fr, fc;
    longint x, y, v, one, a, b, c, d;
    longint res [3];
    longint rows [4];
    logic   fb;
    color_t o;
    one = longint'(1) <<< FRAC;
    h = eff_size(height_q);
    w = eff_size(width_q);
    v = longint'(rpos) - (one >>> 1);
    rb = int'(v >>> FRAC);
    x = v & (one - 1);
    v = longint'(cpos) - (one >>> 1);
    cb = int'(v >>> FRAC);
    y = v & (one - 1);
    if (rb < 0) rb = 0;
    if (cb < 0) cb = 0;
    fb = 1'b0;
    if (mode_q == MODE_BILINEAR) fb = (rb + 1 >= h) || (cb + 1 >= w);
    else if (mode_q == MODE_CUBIC)
      fb = (rb + 3 >= h) || (rb - 1 < 0) || (cb + 2 >= w) || (cb - 1 < 0);
    for (int ch = 0; ch < 3; ch++) begin
      if (mode_q != MODE_BILINEAR && mode_q != MODE_CUBIC) begin
        res[ch] = 0;
      end else if (fb) begin
        fr = rb < h ? rb : h - 1;
        fc = cb < w ? cb : w - 1;
        res[ch] = texel(fr, fc, ch) * one;
      end else if (mode_q == MODE_BILINEAR) begin
        a = texel(rb, cb, ch);
        b = texel(rb + 1, cb, ch);
        c = texel(rb, cb + 1, ch);
        d = texel(rb + 1, cb + 1, ch);
        v = a*one*one + (b - a)*x*one + (c - a)*y*one + (a + d - b - c)*x*y;
        res[ch] = (v + (longint'(1) <<< (2*FRAC - 1))) >>> (2*FRAC);
      end else begin
        for (int i = 0; i < 4; i++)
          rows[i] = cubic4(texel(rb - 1 + i, cb - 1, ch) * one, texel(rb - 1 + i, cb, ch) * one,
                           texel(rb - 1 + i, cb + 1, ch) * one,
                           texel(rb - 1 + i, cb + 2, ch) * one, y);
        res[ch] = cubic4(rows[0], rows[1], rows[2], rows[3], x);
      end
    end
    o.red      = clip(res[0]);
    o.green    = clip(res[1]);
    o.blue     = clip(res[2]);
    o.fallback = fb;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    color_t exp_c;
    if (!rst_ni) begin
      height_q     <= SIZE_W'(SIZE_RESET);
      width_q      <= SIZE_W'(SIZE_RESET);
      mode_q       <= MODE_BILINEAR;
      fail_count_o <= 0;
      samples_o    <= 0;
      color_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.command == CMD_WRITE)
          pixel_mem[{in_i.pixel_row, in_i.pixel_col}] = {in_i.red_in, in_i.green_in, in_i.blue_in};
        else
          color_fifo.push_back(sample_color(in_i.sample_row, in_i.sample_col));
      end
      if (result_o.valid && result_o.ready) begin
        if (color_fifo.size() == 0) begin
          $error("unexpected result transaction");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = color_fifo.pop_front();
          samples_o <= samples_o + 1;
          if (result_o.red_out !== exp_c.red ||
              result_o.green_out !== exp_c.green ||
              result_o.blue_out !== exp_c.blue ||
              result_o.edge_fallback !== exp_c.fallback)
            fail_count_o <= fail_count_o + 1;
          if (result_o.red_out !== exp_c.red)
            $error("red_out expected %0d got %0d", exp_c.red, result_o.red_out);
          if (result_o.green_out !== exp_c.green)
            $error("green_out expected %0d got %0d", exp_c.green, result_o.green_out);
          if (result_o.blue_out !== exp_c.blue)
            $error("blue_out expected %0d got %0d", exp_c.blue, result_o.blue_out);
          if (result_o.edge_fallback !== exp_c.fallback)
            $error("edge_fallback expected %0b got %0b", exp_c.fallback,
                   result_o.edge_fallback);
        end
      end
    end
  end

endmodule

>>> bench/tb_image_bilinear_bicubic_sampler.sv
`timescale 1ns / 100ps

module tb_image_bilinear_bicubic_sampler;
  import ibs_pkg::*;

  localparam logic       CMD_SAMPLE  = ~CMD_WRITE;
  localparam logic [1:0] MODE_BLACK  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 2_500_000;
  localparam int         DRAIN_WAIT  = 80;
  localparam int         FILL_SPAN   = 16;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              calm;
  logic              filled [0:65535];
  int unsigned       fail_count, pending, samples, writes, cycles, phases;
  int                eff_h, eff_w, fill_h, fill_w;

  ibs_in_if  in_ch ();
  ibs_out_if out_ch ();

  image_bilinear_bicubic_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .result_o    (out_ch)
  );

  ibs_sample_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_ch),
    .result_o     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .samples_o    (samples)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  task automatic send_item(logic cmd, logic [7:0] prow, logic [7:0] pcol,
                           logic [23:0] rgb, logic [15:0] srow, logic [15:0] scol);
    if (!calm)
      while ($urandom_range(0, 99) < 35) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.pixel_row  <= prow;
    in_ch.pixel_col  <= pcol;
    in_ch.red_in     <= rgb[23:16];
    in_ch.green_in   <= rgb[15:8];
    in_ch.blue_in    <= rgb[7:0];
    in_ch.sample_row <= srow;
    in_ch.sample_col <= scol;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if (cmd == CMD_WRITE) begin
      filled[{prow, pcol}] = 1'b1;
      writes++;
    end
  endtask

  function automatic logic [23:0] rand_rgb();
    logic [23:0] v;
    v = 24'($urandom);
    if ($urandom_range(0, 4) == 0)
      for (int i = 0; i < 3; i++) v[8*i +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return v;
  endfunction

  task automatic sample_at(logic [15:0] srow, logic [15:0] scol);
    send_item(CMD_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), srow, scol);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // settle the block, reprogram it and write the top-left corner that samples can reach
  task automatic start_phase(logic [8:0] h, logic [8:0] w, logic [1:0] mode);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_MODE, {7'(0), mode});
    eff_h = (h == 0) ? 1 : (h > 256) ? 256 : int'(h);
    eff_w = (w == 0) ? 1 : (w > 256) ? 256 : int'(w);
    fill_h = (eff_h > FILL_SPAN) ? FILL_SPAN : eff_h;
    fill_w = (eff_w > FILL_SPAN) ? FILL_SPAN : eff_w;
    phases++;
    for (int r = 0; r < fill_h; r++)
      for (int c = 0; c < fill_w; c++)
        if (!filled[r*256 + c])
          send_item(CMD_WRITE, 8'(r), 8'(c), rand_rgb(), 16'($urandom), 16'($urandom));
  endtask

  // positions stay inside the written corner unless it covers the whole size
  function automatic logic [15:0] rand_pos(int span, int reach);
    int top;
    if (span == reach) begin
      if ($urandom_range(0, 99) < 12) return 16'($urandom);
      top = span*256 + 384;
    end else begin
      top = (reach - 2)*256 + 127;
    end
    if (top > 65535) top = 65535;
    return 16'($urandom_range(0, top));
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 4) == 0)
          send_item(CMD_WRITE, 8'($urandom), 8'($urandom), rand_rgb(), 16'($urandom),
                    16'($urandom));
        else
          send_item(CMD_WRITE, 8'($urandom_range(0, eff_h - 1)),
                    8'($urandom_range(0, eff_w - 1)), rand_rgb(), 16'($urandom),
                    16'($urandom));
      end else begin
        sample_at(rand_pos(eff_h, fill_h), rand_pos(eff_w, fill_w));
      end
    end
  endtask

  initial begin
    logic [15:0] spots [8];
    logic [1:0]  modes [4];
    logic [1:0]  m;
    spots = '{16'h0000, 16'h0080, 16'h017f, 16'h0180, 16'h0240, 16'h02ff, 16'hffff, 16'h8000};
    modes = '{MODE_BILINEAR, MODE_CUBIC, MODE_BLACK, MODE_SPARE};
    foreach (filled[i]) filled[i] = 1'b0;
    cycles = 0;
    writes = 0;
    phases = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_HEIGHT;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WRITE;
    in_ch.pixel_row = '0;
    in_ch.pixel_col = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.sample_row = '0;
    in_ch.sample_col = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: checkerboard of extremes, corner and half-pixel positions in every mode
    cfg_write(REG_SPARE, 9'h1ff);
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 5; c++)
        send_item(CMD_WRITE, 8'(r), 8'(c), ((r + c) % 2) ? 24'hffffff : 24'h000000, '0, '0);
    foreach (modes[k]) begin
      start_phase(9'd6, 9'd5, modes[k]);
      for (int j = 0; j < 6; j++) sample_at(spots[j], spots[(j + 3) % 8]);
    end
    start_phase(9'd0, 9'd0, MODE_CUBIC);
    sample_at(spots[6], spots[7]);

    for (int p = 0; p < 12; p++) begin
      calm = (p == 4);
      m = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
      if (p == 7) start_phase(9'd1, 9'd16, MODE_BILINEAR);
      else start_phase(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), m);
      random_items(90);
    end
    calm = 1'b0;
    start_phase(9'h1ff, 9'd256, MODE_CUBIC);
    random_items(40);
    start_phase(9'd256, 9'h1ff, MODE_BILINEAR);
    random_items(40);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("covered %0d configuration phases, %0d pixel writes, %0d samples checked",
             phases, writes, samples);
    $display("modes bilinear, cubic and black; sizes 1x1 through full store");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> image_bilinear_bicubic_sampler.f
design/ibs_pkg.sv
design/ibs_ifs.sv
design/ibs_front.sv
design/ibs_queue.sv
design/ibs_back.sv
design/image_bilinear_bicubic_sampler.sv
bench/ibs_sample_checker.sv
bench/tb_image_bilinear_bicubic_sampler.sv
